### rtl/asfs_pkg.sv
`default_nettype none
package asfs_pkg;

    localparam int INDEX_BITS_DEF = 32;

    localparam logic [7:0] PAD_MASK       = 8'h83;
    localparam logic [3:0] MAGIC_FORK_POS = 4'd5;
    localparam logic [3:0] MAGIC_LAST_POS = 4'd8;
    localparam logic [7:0] CH_NEWLINE     = 8'h0a;
    localparam logic [7:0] CH_DASH        = 8'h2d;

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_FRAMES = 2'd1,
        PH_HALT   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_MAGIC = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_DROP  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_PADDING   = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_HALTED    = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_kind;
        logic        frame_start;
        logic        frame_end;
        logic [3:0]  frame_type;
        logic [31:0] frame_index;
        logic        wideband;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic       ok;
        logic [5:0] left;
    } t_flen;

    // expected magic text, wideband spelling; narrowband forks off at position 5
    function automatic logic [7:0] magic_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h23;
            4'd1:    c = 8'h21;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h4d;
            4'd4:    c = 8'h52;
            4'd5:    c = CH_DASH;
            4'd6:    c = 8'h57;
            4'd7:    c = 8'h42;
            4'd8:    c = CH_NEWLINE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // payload bytes after the header: bit count rounded up to bytes
    function automatic t_flen frame_len(input logic wide, input logic [3:0] ft);
        t_flen r;
        r.ok   = 1'b1;
        r.left = 6'd0;
        if (wide) begin
            case (ft)
                4'd0:    r.left = 6'd17;
                4'd1:    r.left = 6'd23;
                4'd2:    r.left = 6'd32;
                4'd3:    r.left = 6'd36;
                4'd4:    r.left = 6'd40;
                4'd5:    r.left = 6'd46;
                4'd6:    r.left = 6'd50;
                4'd7:    r.left = 6'd58;
                4'd8:    r.left = 6'd60;
                4'd9:    r.left = 6'd5;
                4'd14,
                4'd15:   r.left = 6'd0;
                default: r.ok   = 1'b0;
            endcase
        end else begin
            case (ft)
                4'd0:    r.left = 6'd12;
                4'd1:    r.left = 6'd13;
                4'd2:    r.left = 6'd15;
                4'd3:    r.left = 6'd17;
                4'd4:    r.left = 6'd19;
                4'd5:    r.left = 6'd20;
                4'd6:    r.left = 6'd26;
                4'd7:    r.left = 6'd31;
                4'd8:    r.left = 6'd5;
                4'd9:    r.left = 6'd6;
                4'd10:   r.left = 6'd5;
                4'd11:   r.left = 6'd5;
                4'd15:   r.left = 6'd0;
                default: r.ok   = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/amr_storage_frame_splitter.sv
// amr storage-format frame splitter
//
// input channel: i_in_valid / o_in_ready carry one file byte per item, with
// stream_end set on the last byte of the file. output channel: o_out_valid /
// i_out_ready carry one tagged item per input item, in order.
// each byte is registered on entry, then classified (magic text, frame header
// via the frame-type length table, frame body) and the tagged result is
// registered on exit. throughput is one item per cycle while the receiver
// takes results; the parser state (magic position, bytes left in the frame,
// frame counter) updates in the same cycle that moves an item from the input
// register to the result register.
// a held result stalls the transfer; the input register still takes one more
// item, after which o_in_ready drops until the receiver takes the result.
// synchronous active-low reset empties both registers and returns the parser
// to magic matching with frame index zero and no error.
// errors are sticky: after one, every byte is tagged discarded with the code.
// frame_index saturates at 2^INDEX_BITS-1 and shows its low 32 bits.
`default_nettype none
module amr_storage_frame_splitter #(
    parameter int INDEX_BITS = asfs_pkg::INDEX_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire asfs_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output asfs_pkg::t_out_item      o_out_item
);
    import asfs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item w_res;
    logic      w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    asfs_core #(
        .INDEX_BITS(INDEX_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_item (r_in),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule
`default_nettype wire

### rtl/asfs_core.sv
`default_nettype none
module asfs_core #(
    parameter int INDEX_BITS = asfs_pkg::INDEX_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire asfs_pkg::t_in_item  i_item,
    output asfs_pkg::t_out_item      o_res
);
    import asfs_pkg::*;

    localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

    t_phase                r_phase, n_phase;
    logic [3:0]            r_pos, n_pos;
    logic                  r_wide, n_wide;
    logic [5:0]            r_left, n_left;
    logic [3:0]            r_type, n_type;
    logic [INDEX_BITS-1:0] r_cnt, n_cnt;
    t_status               r_code, n_code;

    logic [7:0]            w_b;
    logic                  w_last;
    logic                  w_mag_ok, w_mag_done, w_set_wide;
    logic                  w_pad_bad;
    t_flen                 w_flen;
    logic                  w_frm_end, w_hdr;
    logic [INDEX_BITS+31:0] w_cnt_ext;

    assign w_b       = i_item.data_byte;
    assign w_last    = i_item.stream_end;
    assign w_cnt_ext = {32'd0, r_cnt};

    // decode of the current byte against the current state
    always_comb begin
        w_mag_ok   = 1'b0;
        w_mag_done = 1'b0;
        w_set_wide = 1'b0;
        if (r_pos == MAGIC_FORK_POS) begin
            w_mag_ok   = (w_b == CH_NEWLINE) || (w_b == CH_DASH);
            w_mag_done = (w_b == CH_NEWLINE);
            w_set_wide = (w_b == CH_DASH);
        end else if (r_pos <= MAGIC_LAST_POS) begin
            w_mag_ok   = (w_b == magic_char(r_pos));
            w_mag_done = (r_pos == MAGIC_LAST_POS);
        end
        w_pad_bad = (w_b & PAD_MASK) != 8'd0;
        w_flen    = frame_len(r_wide, w_b[6:3]);
        w_hdr     = (r_left == 6'd0);
        if (w_hdr) begin
            w_frm_end = (w_flen.left == 6'd0);
        end else begin
            w_frm_end = (r_left == 6'd1);
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_wide  = r_wide;
        n_left  = r_left;
        n_type  = r_type;
        n_cnt   = r_cnt;
        n_code  = r_code;
        case (r_phase)
            PH_MAGIC: begin
                if (w_set_wide) begin
                    n_wide = 1'b1;
                end
                if (!w_mag_ok || (w_last && !w_mag_done)) begin
                    n_phase = PH_HALT;
                    n_code  = ST_BAD_MAGIC;
                end else begin
                    n_pos = r_pos + 4'd1;
                    if (w_last) begin
                        n_phase = PH_HALT;
                        n_code  = ST_HALTED;
                    end else if (w_mag_done) begin
                        n_phase = PH_FRAMES;
                    end
                end
            end
            PH_FRAMES: begin
                if (w_hdr && w_pad_bad) begin
                    n_phase = PH_HALT;
                    n_code  = ST_PADDING;
                end else if (w_hdr && !w_flen.ok) begin
                    n_phase = PH_HALT;
                    n_code  = ST_BAD_TYPE;
                end else begin
                    if (w_hdr) begin
                        n_type = w_b[6:3];
                        n_left = w_flen.left;
                    end else begin
                        n_left = r_left - 6'd1;
                    end
                    if (w_frm_end && r_cnt != CNT_MAX) begin
                        n_cnt = r_cnt + INDEX_BITS'(1);
                    end
                    if (w_last) begin
                        n_phase = PH_HALT;
                        n_code  = w_frm_end ? ST_HALTED : ST_TRUNCATED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        o_res.byte_out    = w_b;
        o_res.byte_kind   = KIND_DROP;
        o_res.frame_start = 1'b0;
        o_res.frame_end   = 1'b0;
        o_res.frame_type  = 4'd0;
        o_res.frame_index = w_cnt_ext[31:0];
        o_res.wideband    = n_wide;
        o_res.status      = ST_OK;
        case (r_phase)
            PH_MAGIC: begin
                o_res.frame_index = 32'd0;
                if (!w_mag_ok || (w_last && !w_mag_done)) begin
                    o_res.status = ST_BAD_MAGIC;
                end else begin
                    o_res.byte_kind = KIND_MAGIC;
                end
            end
            PH_FRAMES: begin
                if (w_hdr && w_pad_bad) begin
                    o_res.status = ST_PADDING;
                end else if (w_hdr && !w_flen.ok) begin
                    o_res.status = ST_BAD_TYPE;
                end else begin
                    o_res.byte_kind   = KIND_FRAME;
                    o_res.frame_start = w_hdr;
                    o_res.frame_end   = w_frm_end;
                    o_res.frame_type  = n_type;
                    if (w_last && !w_frm_end) begin
                        o_res.status = ST_TRUNCATED;
                    end
                end
            end
            default: begin
                o_res.status = r_code;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= 4'd0;
            r_wide  <= 1'b0;
            r_left  <= 6'd0;
            r_type  <= 4'd0;
            r_cnt   <= '0;
            r_code  <= ST_OK;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_wide  <= n_wide;
            r_left  <= n_left;
            r_type  <= n_type;
            r_cnt   <= n_cnt;
            r_code  <= n_code;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("left halted phase");

    a_no_magic_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAMES |=> r_phase != PH_MAGIC)
        else $error("returned to magic phase");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.frame_end && r_cnt != CNT_MAX)
            |=> r_cnt == $past(r_cnt) + INDEX_BITS'(1))
        else $error("frame count not advanced on frame end");

endmodule
`default_nettype wire

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asfs_pkg::*;

    localparam int          N_ITEMS      = 650;
    localparam int          N_TAIL       = 20;
    localparam int          IDLE_PCT     = 29;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [31:0] INDEX_MAX    = 32'hffff_ffff;

    localparam int NB_BITS [16] = '{95, 103, 118, 134, 148, 159, 204, 244,
                                    39, 43, 38, 37, 0, 0, 0, 0};
    localparam int WB_BITS [16] = '{132, 177, 253, 285, 317, 365, 397, 461,
                                    477, 40, 0, 0, 0, 0, 0, 0};
    localparam logic [7:0] MAGIC_TEXT [9] = '{8'h23, 8'h21, 8'h41, 8'h4d, 8'h52,
                                              CH_DASH, 8'h57, 8'h42, CH_NEWLINE};

    typedef enum logic [1:0] {
        END_CLEAN,
        END_TRUNCATED,
        END_PADDING,
        END_BAD_TYPE
    } t_ending;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    amr_storage_frame_splitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    t_in_item  byte_q[$];
    t_out_item tag_q[$];

    int      n_sent    = 0;
    int      n_recv    = 0;
    int      n_frames  = 0;
    int      n_errors  = 0;
    int      stall_cnt = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    logic    stream_wide;
    t_ending ending;
    logic    steady;

    // parser state of the predictor
    t_phase      ph        = PH_MAGIC;
    logic [3:0]  mpos      = '0;
    logic        wide      = 1'b0;
    logic [5:0]  left      = '0;
    logic [3:0]  cur_type  = '0;
    logic [31:0] frame_cnt = '0;
    t_status     halt_code = ST_OK;

    // no idling on either side while this window of items goes by
    assign steady = (n_sent >= 120) && (n_sent < 280);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // whole frame in bytes, header included; 0 for a refused type
    function automatic int frame_size(logic w, logic [3:0] ft);
        int bits;
        if (w) begin
            if (ft >= 4'd10 && ft <= 4'd13) return 0;
            bits = WB_BITS[ft];
        end else begin
            if (ft >= 4'd12 && ft <= 4'd14) return 0;
            bits = NB_BITS[ft];
        end
        return (bits + 7) / 8 + 1;
    endfunction

    function automatic void stop_parse(t_status code);
        ph        = PH_HALT;
        halt_code = code;
    endfunction

    function automatic t_out_item predict_tag(t_in_item it);
        t_out_item  r;
        logic [7:0] b;
        logic [3:0] ft;
        logic       ok;
        logic       done;
        logic       fend;
        int         sz;
        b             = it.data_byte;
        r             = '0;
        r.byte_out    = b;
        r.byte_kind   = KIND_DROP;
        r.frame_index = frame_cnt;
        r.status      = ST_OK;
        case (ph)
            PH_MAGIC: begin
                ok            = 1'b0;
                done          = 1'b0;
                r.frame_index = '0;
                if (mpos == MAGIC_FORK_POS) begin
                    // narrowband ends here, wideband goes on with the dash
                    if (b == CH_NEWLINE) begin
                        ok   = 1'b1;
                        done = 1'b1;
                    end else if (b == CH_DASH) begin
                        ok   = 1'b1;
                        wide = 1'b1;
                    end
                end else if (mpos < 4'd9 && b == MAGIC_TEXT[mpos]) begin
                    ok   = 1'b1;
                    done = (mpos == MAGIC_LAST_POS);
                end
                if (!ok || (it.stream_end && !done)) begin
                    r.status = ST_BAD_MAGIC;
                    stop_parse(ST_BAD_MAGIC);
                end else begin
                    r.byte_kind = KIND_MAGIC;
                    mpos        = mpos + 4'd1;
                    if (done) ph = PH_FRAMES;
                    if (it.stream_end) stop_parse(ST_HALTED);
                end
            end
            PH_FRAMES: begin
                ok   = 1'b1;
                fend = 1'b0;
                if (left == '0) begin
                    ft = b[6:3];
                    sz = frame_size(wide, ft);
                    if ((b & PAD_MASK) != '0) begin
                        r.status = ST_PADDING;
                        stop_parse(ST_PADDING);
                        ok = 1'b0;
                    end else if (sz == 0) begin
                        r.status = ST_BAD_TYPE;
                        stop_parse(ST_BAD_TYPE);
                        ok = 1'b0;
                    end else begin
                        cur_type      = ft;
                        left          = 6'(sz - 1);
                        r.frame_start = 1'b1;
                        fend          = (left == '0);
                    end
                end else begin
                    left = left - 6'd1;
                    fend = (left == '0);
                end
                if (ok) begin
                    r.byte_kind  = KIND_FRAME;
                    r.frame_type = cur_type;
                    r.frame_end  = fend;
                    if (fend && frame_cnt != INDEX_MAX) frame_cnt = frame_cnt + 32'd1;
                    if (it.stream_end) begin
                        if (fend) begin
                            stop_parse(ST_HALTED);
                        end else begin
                            r.status = ST_TRUNCATED;
                            stop_parse(ST_TRUNCATED);
                        end
                    end
                end
            end
            default: r.status = halt_code;
        endcase
        r.wideband = wide;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    task automatic push_byte(logic [7:0] b, logic last);
        t_in_item it;
        it.data_byte  = b;
        it.stream_end = last;
        byte_q.push_back(it);
    endtask

    // fill below zero gives random payload bytes
    task automatic push_frame(logic [3:0] ft, int fill);
        logic [7:0] h;
        int         sz;
        sz    = frame_size(stream_wide, ft);
        h     = {1'b0, ft, 3'b000};
        h[2]  = 1'($urandom_range(0, 1));
        push_byte(h, 1'b0);
        for (int k = 1; k < sz; k++) begin
            push_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
        end
    endtask

    initial begin : stimulus
        int         valid_types[$];
        int         idx;
        int         cut;
        int         total;
        logic [3:0] ft;
        logic [7:0] h;
        t_in_item   it;

        stream_wide = 1'($urandom_range(0, 1));
        ending      = t_ending'($urandom_range(0, 3));

        if (stream_wide) begin
            for (int k = 0; k < 9; k++) push_byte(MAGIC_TEXT[k], 1'b0);
        end else begin
            for (int k = 0; k < 5; k++) push_byte(MAGIC_TEXT[k], 1'b0);
            push_byte(CH_NEWLINE, 1'b0);
        end

        // one-byte frames, then two short frames with all-zero and all-one payload
        push_frame(4'd15, -1);
        if (stream_wide) push_frame(4'd14, -1);
        push_frame(stream_wide ? 4'd9 : 4'd8, 8'h00);
        push_frame(stream_wide ? 4'd9 : 4'd8, 8'hff);

        // every valid type once in random order, then random types
        for (int t = 0; t < 16; t++) begin
            if (frame_size(stream_wide, 4'(t)) != 0) valid_types.push_back(t);
        end
        while (byte_q.size() < N_ITEMS) begin
            if (valid_types.size() != 0) begin
                idx = $urandom_range(0, valid_types.size() - 1);
                ft  = 4'(valid_types[idx]);
                valid_types.delete(idx);
            end else begin
                do ft = 4'($urandom_range(0, 15)); while (frame_size(stream_wide, ft) == 0);
            end
            push_frame(ft, -1);
        end

        case (ending)
            END_CLEAN: begin
                it = byte_q.pop_back();
                it.stream_end = 1'b1;
                byte_q.push_back(it);
            end
            END_TRUNCATED: begin
                do ft = 4'($urandom_range(0, 15)); while (frame_size(stream_wide, ft) < 2);
                cut  = $urandom_range(0, frame_size(stream_wide, ft) - 2);
                h    = {1'b0, ft, 3'b000};
                h[2] = 1'($urandom_range(0, 1));
                push_byte(h, cut == 0);
                for (int k = 1; k <= cut; k++) push_byte(8'($urandom_range(0, 255)), k == cut);
            end
            END_PADDING: begin
                do h = 8'($urandom_range(0, 255)); while ((h & PAD_MASK) == '0);
                push_byte(h, 1'b0);
            end
            default: begin
                ft   = stream_wide ? 4'($urandom_range(10, 13)) : 4'($urandom_range(12, 14));
                h    = {1'b0, ft, 3'b000};
                h[2] = 1'($urandom_range(0, 1));
                push_byte(h, 1'b0);
            end
        endcase

        // bytes after the parser has stopped
        for (int k = 0; k < N_TAIL; k++) begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        total = byte_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte must come back tagged before the run closes
        while (n_recv < total) @(posedge i_clk);
        while (tag_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes sent, %0d tagged items checked, %0d frames completed",
                 n_sent, n_recv, n_frames);
        $display("%s magic, stream closed by %s",
                 stream_wide ? "wideband" : "narrowband", ending.name());
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                tag_q.push_back(predict_tag(in_item));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_item  <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (tag_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                    n_errors++;
                end else begin
                    want = tag_q.pop_front();
                    check_field("byte_out", want.byte_out, out_item.byte_out);
                    check_field("byte_kind", want.byte_kind, out_item.byte_kind);
                    check_field("frame_start", want.frame_start, out_item.frame_start);
                    check_field("frame_end", want.frame_end, out_item.frame_end);
                    check_field("frame_type", want.frame_type, out_item.frame_type);
                    check_field("frame_index", want.frame_index, out_item.frame_index);
                    check_field("wideband", want.wideband, out_item.wideband);
                    check_field("status", want.status, out_item.status);
                end
                n_recv <= n_recv + 1;
                if (out_item.frame_end) n_frames <= n_frames + 1;
            end
            // one long hold-off so the input side backs up
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && n_sent >= 350) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
